// File: rtl/trwps_pkg.sv
// ----------------------------------------------------------------------------
// trwps_pkg
// Shared types, codes and helpers for the port scan detector.
// ----------------------------------------------------------------------------
package trwps_pkg;

  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF    = 4;
  localparam int HOSTS_DEF   = 16;

  localparam logic [7:0]  FLAG_SYN    = 8'h02;
  localparam logic [7:0]  FLAG_SYNACK = 8'h12;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;

  localparam logic signed [15:0] THRESH_BENIGN_RST  = -16'sd11789;
  localparam logic signed [15:0] THRESH_SCANNER_RST = 16'sd11789;
  localparam logic signed [15:0] STEP_SUCCESS_RST   = -16'sd1420;
  localparam logic signed [15:0] STEP_FAILURE_RST   = 16'sd1420;
  localparam logic [31:0]        EXPIRE_SPAN_RST    = 32'd3600;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_BENIGN  = 2'd1,
    ST_SCANNER = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    VD_IGNORED = 3'd0,
    VD_PENDING = 3'd1,
    VD_BENIGN  = 3'd2,
    VD_SCANNER = 3'd3,
    VD_DROPPED = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    CFG_THRESH_BENIGN  = 3'd0,
    CFG_THRESH_SCANNER = 3'd1,
    CFG_STEP_SUCCESS   = 3'd2,
    CFG_STEP_FAILURE   = 3'd3,
    CFG_EXPIRE_SPAN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CRC1,
    S_CRC2,
    S_MOD,
    S_WAY_RD,
    S_WAY_CHK,
    S_PICK,
    S_COUNT,
    S_HSCAN,
    S_WIDEN,
    S_SCORE,
    S_DECIDE,
    S_WRITE,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic crc1;
    logic crc2;
    logic mod_step;
    logic way_chk;
    logic pick;
    logic set_decided;
    logic count;
    logic hs_step;
    logic widen_step;
    logic score;
    logic decide;
    logic wr_back;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic syn;
    logic mod_done;
    logic way_last;
    logic found;
    logic freeway;
    logic decided;
    logic hs_done;
    logic seen;
    logic widen_done;
    logic out_free;
  } dp_stat_t;

  // Reflected CRC-32 update by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/trwps_ram.sv
// ----------------------------------------------------------------------------
// trwps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module trwps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/trwps_ctrl.sv
// ----------------------------------------------------------------------------
// trwps_ctrl
// Sequencer for one record: hash, bucket scan, host scan, widen, score.
// ----------------------------------------------------------------------------
module trwps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  trwps_pkg::dp_stat_t   stat,
  output trwps_pkg::ctrl_cmd_t  cmd
);

  trwps_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trwps_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trwps_pkg::S_CLEAR:   if (stat.clr_last) state_nxt = trwps_pkg::S_IDLE;
      trwps_pkg::S_IDLE:    if (in_valid) state_nxt = trwps_pkg::S_CRC1;
      trwps_pkg::S_CRC1:    state_nxt = stat.syn ? trwps_pkg::S_CRC2 : trwps_pkg::S_EMIT;
      trwps_pkg::S_CRC2:    state_nxt = trwps_pkg::S_MOD;
      trwps_pkg::S_MOD:     if (stat.mod_done) state_nxt = trwps_pkg::S_WAY_RD;
      trwps_pkg::S_WAY_RD:  state_nxt = trwps_pkg::S_WAY_CHK;
      trwps_pkg::S_WAY_CHK: begin
        state_nxt = stat.way_last ? trwps_pkg::S_PICK : trwps_pkg::S_WAY_RD;
      end
      trwps_pkg::S_PICK: begin
        state_nxt = (stat.found || stat.freeway) ? trwps_pkg::S_COUNT : trwps_pkg::S_EMIT;
      end
      trwps_pkg::S_COUNT: begin
        state_nxt = stat.decided ? trwps_pkg::S_EMIT : trwps_pkg::S_HSCAN;
      end
      trwps_pkg::S_HSCAN: begin
        if (stat.hs_done) begin
          state_nxt = stat.seen ? trwps_pkg::S_WRITE : trwps_pkg::S_WIDEN;
        end
      end
      trwps_pkg::S_WIDEN:   if (stat.widen_done) state_nxt = trwps_pkg::S_SCORE;
      trwps_pkg::S_SCORE:   state_nxt = trwps_pkg::S_DECIDE;
      trwps_pkg::S_DECIDE:  state_nxt = trwps_pkg::S_WRITE;
      trwps_pkg::S_WRITE:   state_nxt = trwps_pkg::S_EMIT;
      trwps_pkg::S_EMIT:    if (stat.out_free) state_nxt = trwps_pkg::S_IDLE;
      default:              state_nxt = trwps_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      trwps_pkg::S_CLEAR:   cmd.clr = 1'b1;
      trwps_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      trwps_pkg::S_CRC1:    cmd.crc1 = 1'b1;
      trwps_pkg::S_CRC2:    cmd.crc2 = 1'b1;
      trwps_pkg::S_MOD:     cmd.mod_step = !stat.mod_done;
      trwps_pkg::S_WAY_RD:  cmd = '0;
      trwps_pkg::S_WAY_CHK: cmd.way_chk = 1'b1;
      trwps_pkg::S_PICK:    cmd.pick = 1'b1;
      trwps_pkg::S_COUNT: begin
        cmd.set_decided = stat.decided;
        cmd.count       = !stat.decided;
      end
      trwps_pkg::S_HSCAN:   cmd.hs_step = !stat.hs_done;
      trwps_pkg::S_WIDEN:   cmd.widen_step = !stat.widen_done;
      trwps_pkg::S_SCORE:   cmd.score = 1'b1;
      trwps_pkg::S_DECIDE:  cmd.decide = 1'b1;
      trwps_pkg::S_WRITE:   cmd.wr_back = 1'b1;
      trwps_pkg::S_EMIT:    cmd.emit = stat.out_free;
      default:              cmd = '0;
    endcase
  end

endmodule

// File: rtl/trwps_dp.sv
// ----------------------------------------------------------------------------
// trwps_dp
// Datapath: config registers, hash and bucket unit, slot and host tables,
// widen, score and the output register.
// ----------------------------------------------------------------------------
module trwps_dp #(
  parameter int BUCKETS = trwps_pkg::BUCKETS_DEF,
  parameter int WAYS    = trwps_pkg::WAYS_DEF,
  parameter int HOSTS   = trwps_pkg::HOSTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [31:0]          in_source_ip,
  input  logic [31:0]          in_dest_ip,
  input  logic [7:0]           in_source_flags,
  input  logic [7:0]           in_dest_flags,
  input  logic [31:0]          in_now_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_verdict,
  output logic                 out_became_scanner,
  output logic                 out_new_host,
  output logic signed [15:0]   out_score,
  output logic [31:0]          out_subnet_base,
  output logic [31:0]          out_subnet_mask,
  output logic [15:0]          out_success_count,
  output logic [15:0]          out_failure_count,
  input  trwps_pkg::ctrl_cmd_t cmd,
  output trwps_pkg::dp_stat_t  stat
);

  localparam int NSLOTS  = BUCKETS * WAYS;
  localparam int NHOST   = NSLOTS * HOSTS;
  localparam int SAW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int HAW     = (NHOST > 1) ? $clog2(NHOST) : 1;
  localparam int FW      = $clog2(HOSTS + 1);
  localparam int WCW     = $clog2(WAYS + 1);
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int BL      = $clog2(BUCKETS);
  // rounded-up reciprocal of BUCKETS, exact quotient for any 32-bit value
  localparam logic [64:0] RECIP = ((65'd1 << (32 + BL)) + 65'(BUCKETS) - 65'd1)
                                  / 65'(BUCKETS);

  typedef struct packed {
    logic               valid;
    logic [31:0]        source;
    logic [31:0]        subnet;
    logic [31:0]        mask;
    logic [15:0]        fail;
    logic [15:0]        succ;
    logic [31:0]        expiry;
    logic [1:0]         status;
    logic signed [15:0] score;
    logic [FW-1:0]      fill;
  } rec_t;

  localparam int RW = $bits(rec_t);

  // configuration
  logic signed [15:0] tb_r, ts_r, ss_r, sf_r;
  logic [31:0]        span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r   <= trwps_pkg::THRESH_BENIGN_RST;
      ts_r   <= trwps_pkg::THRESH_SCANNER_RST;
      ss_r   <= trwps_pkg::STEP_SUCCESS_RST;
      sf_r   <= trwps_pkg::STEP_FAILURE_RST;
      span_r <= trwps_pkg::EXPIRE_SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trwps_pkg::CFG_THRESH_BENIGN:  tb_r   <= cfg_wdata[15:0];
        trwps_pkg::CFG_THRESH_SCANNER: ts_r   <= cfg_wdata[15:0];
        trwps_pkg::CFG_STEP_SUCCESS:   ss_r   <= cfg_wdata[15:0];
        trwps_pkg::CFG_STEP_FAILURE:   sf_r   <= cfg_wdata[15:0];
        trwps_pkg::CFG_EXPIRE_SPAN:    span_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured record and working state
  logic [31:0]   src_r, dst_r, now_r;
  logic          syn_r, succ_r;
  logic [31:0]   crc_r, rem_r;
  logic [5:0]    mod_k_r;
  logic [48:0]   pl_r, ph_r;
  logic [31:0]   q_r;
  logic [WCW-1:0] way_r;
  logic          found_r, free_r, seen_r, pend_r, zero_r, newh_r, became_r;
  logic [SAW-1:0] slot_r, free_slot_r, clr_r;
  logic [FW-1:0] fillc_r, k_r;
  logic [2:0]    vd_r;
  rec_t          rec_r;

  // tables
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [RW-1:0]  s_wdata, s_rdata;
  logic           h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [31:0]    h_rdata;
  rec_t           way_rec;

  trwps_ram #(.WIDTH(RW), .DEPTH(NSLOTS)) u_slot_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  trwps_ram #(.WIDTH(32), .DEPTH(NHOST)) u_host_ram (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(dst_r),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  // bucket index and addresses
  logic [31:0] bucket32;
  logic        way_exp, way_eff;

  assign bucket32 = IS_POW2 ? (rem_r & 32'(BUCKETS - 1)) : rem_r;
  assign s_raddr  = SAW'(bucket32 * 32'(WAYS) + 32'(way_r));
  assign h_raddr  = HAW'(32'(slot_r) * 32'(HOSTS) + 32'(k_r));
  assign h_waddr  = HAW'(32'(slot_r) * 32'(HOSTS) + 32'(fillc_r));
  assign h_we     = cmd.score && (fillc_r < FW'(HOSTS));
  assign way_rec  = rec_t'(s_rdata);
  assign way_exp  = way_rec.valid && (way_rec.status != trwps_pkg::ST_PENDING)
                    && (now_r > way_rec.expiry);
  assign way_eff  = way_rec.valid && !way_exp;

  always_comb begin
    rec_t wb;
    wb       = way_rec;
    wb.valid = 1'b0;
    s_we     = 1'b0;
    s_waddr  = slot_r;
    s_wdata  = rec_r;
    if (cmd.clr) begin
      s_we    = 1'b1;
      s_waddr = clr_r;
      s_wdata = '0;
    end else if (cmd.way_chk && way_exp) begin
      s_we    = 1'b1;
      s_waddr = s_raddr;
      s_wdata = wb;
    end else if (cmd.wr_back) begin
      s_we    = 1'b1;
    end
  end

  // score step with clamp
  logic signed [16:0] sc_sum;
  logic signed [15:0] sc_sat;
  logic [32:0]        exp_sum;

  assign sc_sum  = {rec_r.score[15], rec_r.score} + (succ_r ? {ss_r[15], ss_r} : {sf_r[15], sf_r});
  assign sc_sat  = (sc_sum[16] != sc_sum[15]) ? (sc_sum[16] ? 16'sh8000 : 16'sh7FFF)
                                              : sc_sum[15:0];
  assign exp_sum = {1'b0, now_r} + {1'b0, span_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      src_r    <= in_source_ip;
      dst_r    <= in_dest_ip;
      now_r    <= in_now_time;
      syn_r    <= (in_source_flags & trwps_pkg::FLAG_SYN) != 8'd0;
      succ_r   <= (in_dest_flags & trwps_pkg::FLAG_SYNACK) == trwps_pkg::FLAG_SYNACK;
      vd_r     <= trwps_pkg::VD_IGNORED;
      zero_r   <= 1'b1;
      newh_r   <= 1'b0;
      became_r <= 1'b0;
      found_r  <= 1'b0;
      free_r   <= 1'b0;
      way_r    <= '0;
    end
    if (cmd.crc1) begin
      crc_r <= trwps_pkg::crc_byte(trwps_pkg::ALL_ONES, src_r[15:8]);
    end
    if (cmd.crc2) begin
      rem_r   <= trwps_pkg::crc_byte(crc_r, src_r[7:0]) ^ trwps_pkg::ALL_ONES;
      mod_k_r <= 6'd0;
    end
    if (cmd.mod_step) begin
      // remainder by reciprocal multiply: partial products, quotient, subtract
      case (mod_k_r)
        6'd0: begin
          pl_r <= rem_r * RECIP[16:0];
          ph_r <= rem_r * RECIP[33:17];
        end
        6'd1:    q_r <= 32'(({ph_r, 17'd0} + {17'd0, pl_r}) >> (32 + BL));
        default: rem_r <= rem_r - q_r * 32'(BUCKETS);
      endcase
      mod_k_r <= mod_k_r + 6'd1;
    end
    if (cmd.way_chk) begin
      if (!found_r && way_eff && (way_rec.source == src_r)) begin
        found_r <= 1'b1;
        slot_r  <= s_raddr;
        rec_r   <= way_rec;
      end
      if (!free_r && !way_eff) begin
        free_r      <= 1'b1;
        free_slot_r <= s_raddr;
      end
      way_r <= way_r + 1'b1;
    end
    if (cmd.pick) begin
      if (!found_r && free_r) begin
        slot_r        <= free_slot_r;
        rec_r.valid   <= 1'b1;
        rec_r.source  <= src_r;
        rec_r.subnet  <= '0;
        rec_r.mask    <= trwps_pkg::ALL_ONES;
        rec_r.succ    <= '0;
        rec_r.fail    <= '0;
        rec_r.expiry  <= '0;
        rec_r.status  <= trwps_pkg::ST_PENDING;
        rec_r.score   <= '0;
        rec_r.fill    <= '0;
      end else if (!found_r) begin
        vd_r <= trwps_pkg::VD_DROPPED;
      end
    end
    if (cmd.set_decided) begin
      zero_r <= 1'b0;
      vd_r   <= (rec_r.status == trwps_pkg::ST_BENIGN) ? trwps_pkg::VD_BENIGN
                                                       : trwps_pkg::VD_SCANNER;
    end
    if (cmd.count) begin
      zero_r <= 1'b0;
      vd_r   <= trwps_pkg::VD_PENDING;
      if (succ_r) begin
        if (rec_r.succ != 16'hFFFF) rec_r.succ <= rec_r.succ + 16'd1;
      end else begin
        if (rec_r.fail != 16'hFFFF) rec_r.fail <= rec_r.fail + 16'd1;
      end
      fillc_r <= (rec_r.fill > FW'(HOSTS)) ? FW'(HOSTS) : rec_r.fill;
      k_r     <= '0;
      pend_r  <= 1'b0;
      seen_r  <= 1'b0;
    end
    if (cmd.hs_step) begin
      if (pend_r && (h_rdata == dst_r)) begin
        seen_r <= 1'b1;
      end
      pend_r <= (k_r < fillc_r);
      if (k_r < fillc_r) begin
        k_r <= k_r + 1'b1;
      end
    end
    if (cmd.widen_step) begin
      if (fillc_r == '0) begin
        rec_r.subnet <= dst_r;
      end else begin
        rec_r.mask   <= rec_r.mask << 1;
        rec_r.subnet <= rec_r.subnet & (rec_r.mask << 1);
      end
    end
    if (cmd.score) begin
      rec_r.score <= sc_sat;
      newh_r      <= 1'b1;
      if (fillc_r < FW'(HOSTS)) begin
        rec_r.fill <= fillc_r + 1'b1;
      end
    end
    if (cmd.decide) begin
      if ((rec_r.score < tb_r) || (rec_r.score > ts_r)) begin
        rec_r.expiry <= exp_sum[32] ? trwps_pkg::ALL_ONES : exp_sum[31:0];
        if (rec_r.score < tb_r) begin
          rec_r.status <= trwps_pkg::ST_BENIGN;
          vd_r         <= trwps_pkg::VD_BENIGN;
        end else begin
          rec_r.status <= trwps_pkg::ST_SCANNER;
          vd_r         <= trwps_pkg::VD_SCANNER;
          became_r     <= 1'b1;
        end
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_verdict        <= vd_r;
      out_became_scanner <= became_r;
      out_new_host       <= newh_r;
      out_score          <= zero_r ? '0 : rec_r.score;
      out_subnet_base    <= zero_r ? '0 : rec_r.subnet;
      out_subnet_mask    <= zero_r ? '0 : rec_r.mask;
      out_success_count  <= zero_r ? '0 : rec_r.succ;
      out_failure_count  <= zero_r ? '0 : rec_r.fail;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    stat            = '0;
    stat.clr_last   = (clr_r == SAW'(NSLOTS - 1));
    stat.syn        = syn_r;
    stat.mod_done   = IS_POW2 || (mod_k_r == 6'd3);
    stat.way_last   = (way_r == WCW'(WAYS - 1));
    stat.found      = found_r;
    stat.freeway    = free_r;
    stat.decided    = (rec_r.status != trwps_pkg::ST_PENDING);
    stat.hs_done    = (k_r == fillc_r) && !pend_r;
    stat.seen       = seen_r;
    stat.widen_done = ((rec_r.subnet & rec_r.mask) == (dst_r & rec_r.mask));
    stat.out_free   = !out_valid_r || !out_stall;
  end

endmodule

// File: rtl/trw_portscan_detector_unit.sv
// ----------------------------------------------------------------------------
// trw_portscan_detector_unit
// Threshold random walk port scan detector, one connection word at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall) carries one connection word: source
//    and destination address, TCP flags of both sides and a time stamp.
//  - Output channel (out_valid / out_stall) returns one result word per input
//    word: verdict, score, aggregated subnet and the attempt counters.
//  - Config port (cfg_we / cfg_index / cfg_wdata) sets thresholds, score
//    steps and expiry span; write it only while the unit is idle.
//  - Work per word depends on its kind: no SYN, dropped, decided source,
//    repeated host or new host; it grows with WAYS, with fill (hosts already
//    stored for the source) and with widen (prefix bits dropped), and the
//    bucket reduction adds to it when BUCKETS is not a power of two. The
//    bucket scan reads one way at a time and the host scan one host per
//    cycle; one word is in work at a time.
//  - After reset the slot table is cleared, one entry per cycle, all
//    BUCKETS*WAYS entries (1024 by default); in_stall stays high meanwhile.
//  - A finished result waits in the output register while out_stall is
//    high; the next input word is still taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module trw_portscan_detector_unit #(
  parameter int BUCKETS = trwps_pkg::BUCKETS_DEF,
  parameter int WAYS    = trwps_pkg::WAYS_DEF,
  parameter int HOSTS   = trwps_pkg::HOSTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_source_ip,
  input  logic [31:0]        in_dest_ip,
  input  logic [7:0]         in_source_flags,
  input  logic [7:0]         in_dest_flags,
  input  logic [31:0]        in_now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_verdict,
  output logic               out_became_scanner,
  output logic               out_new_host,
  output logic signed [15:0] out_score,
  output logic [31:0]        out_subnet_base,
  output logic [31:0]        out_subnet_mask,
  output logic [15:0]        out_success_count,
  output logic [15:0]        out_failure_count
);

  // command and status between sequencer and datapath
  trwps_pkg::ctrl_cmd_t cmd;
  trwps_pkg::dp_stat_t  stat;

  // sequencer: clear pass, then one word from accept to result
  trwps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: tables, hash, widen, score, output register
  trwps_dp #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS),
    .HOSTS  (HOSTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_source_ip      (in_source_ip),
    .in_dest_ip        (in_dest_ip),
    .in_source_flags   (in_source_flags),
    .in_dest_flags     (in_dest_flags),
    .in_now_time       (in_now_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict),
    .out_became_scanner(out_became_scanner),
    .out_new_host      (out_new_host),
    .out_score         (out_score),
    .out_subnet_base   (out_subnet_base),
    .out_subnet_mask   (out_subnet_mask),
    .out_success_count (out_success_count),
    .out_failure_count (out_failure_count),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

// File: rtl/trwps_chk.sv
// ----------------------------------------------------------------------------
// trwps_chk
// Port-level checks for the port scan detector, bound to the top level.
// ----------------------------------------------------------------------------
module trwps_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_verdict,
  input logic               out_became_scanner,
  input logic               out_new_host,
  input logic signed [15:0] out_score,
  input logic [31:0]        out_subnet_mask,
  input logic [15:0]        out_success_count,
  input logic [15:0]        out_failure_count
);

  // hold off input through reset and the clear pass start
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == 3'(trwps_pkg::VD_IGNORED)
                  || out_verdict == 3'(trwps_pkg::VD_DROPPED))
    |-> out_score == '0 && out_subnet_mask == '0 && out_success_count == '0
        && out_failure_count == '0 && !out_new_host && !out_became_scanner)
    else $error("ignored or dropped word carries data");

  a_became: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_became_scanner
    |-> out_new_host && out_verdict == 3'(trwps_pkg::VD_SCANNER))
    else $error("scanner transition without new host");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled result dropped or changed");

endmodule

bind trw_portscan_detector_unit trwps_chk u_trwps_chk (.*);

// File: sim/trw_portscan_detector_unit_test.sv
// ----------------------------------------------------------------------------
// trw_portscan_detector_unit_test
// Self-checking bench for the threshold random walk port scan detector: a
// directed table and then random connection words, each result checked
// against a cycle-free predictor of the slot table, with random idling on
// both channels and several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module trw_portscan_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKET = 256;
  localparam int NWAY    = 4;
  localparam int NHOST   = 16;
  localparam int NSLOT   = NBUCKET * NWAY;

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  sflags;
    logic [7:0]  dflags;
    logic [31:0] now;
  } conn_t;

  typedef struct {
    trwps_pkg::verdict_t verdict;
    logic               became;
    logic               newh;
    logic signed [15:0] score;
    logic [31:0]        base;
    logic [31:0]        mask;
    logic [15:0]        succ;
    logic [15:0]        fail;
  } judgement_t;

  typedef struct {
    conn_t      c;
    bit         typed;
    judgement_t j;
  } table_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [31:0] in_source_ip, in_dest_ip, in_now_time;
  logic [7:0] in_source_flags, in_dest_flags;
  logic out_valid, out_stall;
  logic [2:0] out_verdict;
  logic out_became_scanner, out_new_host;
  logic signed [15:0] out_score;
  logic [31:0] out_subnet_base, out_subnet_mask;
  logic [15:0] out_success_count, out_failure_count;

  trw_portscan_detector_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_source_ip(in_source_ip), .in_dest_ip(in_dest_ip),
    .in_source_flags(in_source_flags), .in_dest_flags(in_dest_flags),
    .in_now_time(in_now_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_verdict(out_verdict), .out_became_scanner(out_became_scanner),
    .out_new_host(out_new_host), .out_score(out_score),
    .out_subnet_base(out_subnet_base), .out_subnet_mask(out_subnet_mask),
    .out_success_count(out_success_count), .out_failure_count(out_failure_count)
  );

  // Mirror of the detector's registers and slot table.
  int          lim_benign, lim_scanner, inc_success, inc_failure;
  logic [31:0] hold_span;
  bit          s_valid [NSLOT];
  logic [31:0] s_source [NSLOT];
  logic [31:0] s_subnet [NSLOT];
  logic [31:0] s_mask [NSLOT];
  logic [15:0] s_succ [NSLOT];
  logic [15:0] s_fail [NSLOT];
  logic [31:0] s_expiry [NSLOT];
  trwps_pkg::slot_st_t s_state [NSLOT];
  int          s_score [NSLOT];
  int          s_fill [NSLOT];
  logic [31:0] s_hosts [NSLOT*NHOST];

  judgement_t pending_results[$];
  table_row_t stim_rows[$];
  int         errors;
  bit         calm;          // no idling on either side while set
  logic [31:0] clock_now;    // running time stamp for random words
  logic [31:0] src_pool[32];
  logic [31:0] dst_pool[24];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] bucket_of(logic [31:0] ip);
    logic [31:0] c;
    logic [7:0]  octet;
    c = 32'hFFFFFFFF;
    for (int b = 0; b < 2; b++) begin
      octet = (b == 0) ? ip[15:8] : ip[7:0];
      c = c ^ {24'd0, octet};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    c = ~c;
    return c[7:0];
  endfunction

  function automatic judgement_t report(int s, trwps_pkg::verdict_t v, logic became,
                                        logic newh);
    judgement_t j;
    j.verdict = v;
    j.became  = became;
    j.newh    = newh;
    j.score   = s_score[s][15:0];
    j.base    = s_subnet[s];
    j.mask    = s_mask[s];
    j.succ    = s_succ[s];
    j.fail    = s_fail[s];
    return j;
  endfunction

  // Advance the slot table by one connection word and return its judgement.
  function automatic judgement_t judge_connection(conn_t c);
    judgement_t j;
    int base, s, fill, sc;
    bit found, hit, seen, ok;
    logic [31:0] e;
    j = '{verdict: trwps_pkg::VD_IGNORED, default: '0};
    if ((c.sflags & trwps_pkg::FLAG_SYN) == 8'd0) return j;
    base = int'(bucket_of(c.src)) * NWAY;
    // free decided entries whose hold time ran out
    for (int w = 0; w < NWAY; w++)
      if (s_valid[base+w] && s_state[base+w] != trwps_pkg::ST_PENDING
          && c.now > s_expiry[base+w])
        s_valid[base+w] = 0;
    found = 0;
    s = 0;
    for (int w = 0; w < NWAY; w++)
      if (!found && s_valid[base+w] && s_source[base+w] == c.src) begin
        s = base + w;
        found = 1;
      end
    if (!found) begin
      hit = 0;
      for (int w = 0; w < NWAY; w++)
        if (!hit && !s_valid[base+w]) begin
          s = base + w;
          hit = 1;
        end
      if (!hit) begin
        j.verdict = trwps_pkg::VD_DROPPED;
        return j;
      end
      s_valid[s] = 1;  s_source[s] = c.src;  s_subnet[s] = '0;  s_mask[s] = '1;
      s_succ[s] = '0;  s_fail[s] = '0;  s_expiry[s] = '0;
      s_state[s] = trwps_pkg::ST_PENDING;
      s_score[s] = 0;  s_fill[s] = 0;
    end
    if (s_state[s] != trwps_pkg::ST_PENDING)
      return report(s, (s_state[s] == trwps_pkg::ST_BENIGN) ? trwps_pkg::VD_BENIGN
                                                            : trwps_pkg::VD_SCANNER, 0, 0);

    ok = (c.dflags & trwps_pkg::FLAG_SYNACK) == trwps_pkg::FLAG_SYNACK;
    if (ok) begin
      if (s_succ[s] != 16'hFFFF) s_succ[s]++;
    end else begin
      if (s_fail[s] != 16'hFFFF) s_fail[s]++;
    end
    fill = (s_fill[s] > NHOST) ? NHOST : s_fill[s];
    seen = 0;
    for (int k = 0; k < fill; k++) if (s_hosts[s*NHOST+k] == c.dst) seen = 1;
    if (seen) return report(s, trwps_pkg::VD_PENDING, 0, 0);

    if (fill == 0) s_subnet[s] = c.dst;
    else
      while ((s_subnet[s] & s_mask[s]) != (c.dst & s_mask[s])) begin
        s_mask[s] = s_mask[s] << 1;
        s_subnet[s] &= s_mask[s];
      end
    if (fill < NHOST) begin
      s_hosts[s*NHOST+fill] = c.dst;
      s_fill[s] = fill + 1;
    end
    sc = s_score[s] + (ok ? inc_success : inc_failure);
    if (sc > 32767) sc = 32767;
    if (sc < -32768) sc = -32768;
    s_score[s] = sc;
    if (sc < lim_benign || sc > lim_scanner) begin
      e = c.now + hold_span;
      if (e < c.now) e = 32'hFFFFFFFF;
      s_expiry[s] = e;
      if (sc < lim_benign) begin
        s_state[s] = trwps_pkg::ST_BENIGN;
        return report(s, trwps_pkg::VD_BENIGN, 0, 1);
      end
      s_state[s] = trwps_pkg::ST_SCANNER;
      return report(s, trwps_pkg::VD_SCANNER, 1, 1);
    end
    return report(s, trwps_pkg::VD_PENDING, 0, 1);
  endfunction

  // Append one row to the directed table.
  task automatic add_row(conn_t c, bit typed, judgement_t j);
    table_row_t row;
    row.c     = c;
    row.typed = typed;
    row.j     = j;
    stim_rows = {stim_rows, row};
  endtask

  // Hand one word to the detector, then log what it should return.
  task automatic send_conn(conn_t c, bit typed, judgement_t want);
    int gap;
    bit taken;
    judgement_t got;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_source_ip    <= c.src;
    in_dest_ip      <= c.dst;
    in_source_flags <= c.sflags;
    in_dest_flags   <= c.dflags;
    in_now_time     <= c.now;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    got = judge_connection(c);
    if (typed) got = want;
    pending_results = {pending_results, got};
  endtask

  // Drop valid and let every outstanding result drain before touching registers.
  task automatic drain;
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(trwps_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      trwps_pkg::CFG_THRESH_BENIGN:  lim_benign  = int'($signed(val[15:0]));
      trwps_pkg::CFG_THRESH_SCANNER: lim_scanner = int'($signed(val[15:0]));
      trwps_pkg::CFG_STEP_SUCCESS:   inc_success = int'($signed(val[15:0]));
      trwps_pkg::CFG_STEP_FAILURE:   inc_failure = int'($signed(val[15:0]));
      default:                       hold_span   = val;
    endcase
  endtask

  task automatic set_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] up,
                          logic [15:0] dn, logic [31:0] span);
    write_reg(trwps_pkg::CFG_THRESH_BENIGN, {16'd0, lo});
    write_reg(trwps_pkg::CFG_THRESH_SCANNER, {16'd0, hi});
    write_reg(trwps_pkg::CFG_STEP_SUCCESS, {16'd0, up});
    write_reg(trwps_pkg::CFG_STEP_FAILURE, {16'd0, dn});
    write_reg(trwps_pkg::CFG_EXPIRE_SPAN, span);
  endtask

  // Mostly SYN words from a small set of sources and hosts so that entries
  // walk all the way to a decision; the rest is noise.
  function automatic conn_t random_conn();
    conn_t c;
    int r;
    r = $urandom_range(0, 99);
    c.src = (r < 90) ? src_pool[$urandom_range(0, 31)] : $urandom;
    r = $urandom_range(0, 99);
    if (r < 60) c.dst = dst_pool[$urandom_range(0, 23)];
    else if (r < 85) c.dst = dst_pool[$urandom_range(0, 23)] ^ (32'd1 << $urandom_range(0, 31));
    else c.dst = $urandom;
    c.sflags = 8'($urandom);
    if ($urandom_range(0, 99) < 88) c.sflags |= trwps_pkg::FLAG_SYN;
    c.dflags = 8'($urandom);
    if ($urandom_range(0, 1)) c.dflags |= trwps_pkg::FLAG_SYNACK;
    r = $urandom_range(0, 99);
    if (r < 3) clock_now = $urandom;
    else if (r < 10) clock_now = clock_now + $urandom_range(1000, 20000);
    else clock_now = clock_now + $urandom_range(0, 60);
    c.now = clock_now;
    return c;
  endfunction

  task automatic random_run(int n);
    judgement_t none;
    none = '{verdict: trwps_pkg::VD_IGNORED, default: '0};
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 0) calm = ($urandom_range(0, 4) == 0);
      send_conn(random_conn(), 0, none);
    end
    calm = 0;
  endtask

  // Receiver: hold off a random number of cycles, then take one word.
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = calm ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Checker: a word moves at the next edge when valid is up and stall is down.
  always @(negedge clk) begin
    judgement_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word, verdict %0d", out_verdict);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (out_verdict !== w.verdict) begin
          $error("verdict: expected %0d, got %0d", w.verdict, out_verdict); errors++;
        end
        if (out_became_scanner !== w.became) begin
          $error("became_scanner: expected %0d, got %0d", w.became, out_became_scanner);
          errors++;
        end
        if (out_new_host !== w.newh) begin
          $error("new_host: expected %0d, got %0d", w.newh, out_new_host); errors++;
        end
        if (out_score !== w.score) begin
          $error("score: expected %0d, got %0d", w.score, out_score); errors++;
        end
        if (out_subnet_base !== w.base) begin
          $error("subnet_base: expected %h, got %h", w.base, out_subnet_base); errors++;
        end
        if (out_subnet_mask !== w.mask) begin
          $error("subnet_mask: expected %h, got %h", w.mask, out_subnet_mask); errors++;
        end
        if (out_success_count !== w.succ) begin
          $error("success_count: expected %0d, got %0d", w.succ, out_success_count); errors++;
        end
        if (out_failure_count !== w.fail) begin
          $error("failure_count: expected %0d, got %0d", w.fail, out_failure_count); errors++;
        end
      end
    end
  end

  initial begin
    judgement_t zero, none, first;
    logic [31:0] crowd[5];
    logic [31:0] a;
    int n;

    errors = 0;
    calm = 0;
    clock_now = 32'd100;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_source_ip    <= '0;
    in_dest_ip      <= '0;
    in_source_flags <= '0;
    in_dest_flags   <= '0;
    in_now_time     <= '0;
    lim_benign  = int'(trwps_pkg::THRESH_BENIGN_RST);
    lim_scanner = int'(trwps_pkg::THRESH_SCANNER_RST);
    inc_success = int'(trwps_pkg::STEP_SUCCESS_RST);
    inc_failure = int'(trwps_pkg::STEP_FAILURE_RST);
    hold_span   = trwps_pkg::EXPIRE_SPAN_RST;
    foreach (s_valid[i]) s_valid[i] = 0;

    // Five sources sharing one bucket: four fill it, the fifth is dropped.
    n = 0;
    while (n < 5) begin
      a = $urandom;
      if (bucket_of(a) == 8'd77) begin
        crowd[n] = a;
        n++;
      end
    end
    for (int i = 0; i < 32; i++) src_pool[i] = (i < 5) ? crowd[i] : $urandom;
    for (int i = 0; i < 24; i++)
      dst_pool[i] = (i < 12) ? {24'h0A0B0C, 8'($urandom)} : $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    zero = '{verdict: trwps_pkg::VD_IGNORED, default: '0};
    none = zero;
    // no SYN: ignored, everything else zero
    add_row('{32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00, 8'hFF, 32'hFFFFFFFF}, 1, zero);
    add_row('{32'h0, 32'h0, 8'hFD, 8'h12, 32'h0}, 1, zero);
    // first host of a fresh source, successful reply
    first = '{trwps_pkg::VD_PENDING, 1'b0, 1'b1, -16'sd1420, 32'hFFFFFFFF, 32'hFFFFFFFF,
              16'd1, 16'd0};
    add_row('{32'hFFFFFFFF, 32'hFFFFFFFF, trwps_pkg::FLAG_SYN, trwps_pkg::FLAG_SYNACK,
              32'd0}, 1, first);
    // repeated host, then the widest widening
    add_row('{32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 32'd1}, 0, none);
    add_row('{32'hFFFFFFFF, 32'h0, trwps_pkg::FLAG_SYN, 8'h02, 32'd2}, 0, none);
    add_row('{32'h0, 32'h0, 8'hFF, 8'h10, 32'hFFFFFFFF}, 0, none);
    for (int i = 0; i < 4; i++)
      add_row('{crowd[i], dst_pool[i], trwps_pkg::FLAG_SYN, 8'h00, 32'd5}, 0, none);
    add_row('{crowd[4], dst_pool[0], trwps_pkg::FLAG_SYN, 8'h00, 32'd6},
            1, '{verdict: trwps_pkg::VD_DROPPED, default: '0});
    // one source failing against ten fresh hosts turns into a scanner
    for (int i = 0; i < 10; i++)
      add_row('{32'hC0A80001, dst_pool[i], trwps_pkg::FLAG_SYN, 8'h04, 32'd10 + i},
              0, none);
    // decided entry reports stored values; after expiry it starts over
    add_row('{32'hC0A80001, dst_pool[20], trwps_pkg::FLAG_SYN, trwps_pkg::FLAG_SYNACK,
              32'd50}, 0, none);
    add_row('{32'hC0A80001, dst_pool[21], trwps_pkg::FLAG_SYN, trwps_pkg::FLAG_SYNACK,
              32'd9000}, 0, none);

    foreach (stim_rows[i]) send_conn(stim_rows[i].c, stim_rows[i].typed, stim_rows[i].j);
    random_run(400);
    drain();

    // Thresholds out of reach, steps at the extremes: scores clamp, host lists fill.
    set_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'd0);
    random_run(400);
    drain();

    // Near thresholds and the longest hold time: expiry saturates.
    set_regs(-16'sd2000, 16'sd2000, -16'sd700, 16'sd700, 32'hFFFFFFFF);
    random_run(400);
    drain();

    // Random settings.
    for (int p = 0; p < 3; p++) begin
      set_regs(-16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
               16'($urandom), 16'($urandom), $urandom_range(0, 5000));
      random_run(140);
      drain();
    end

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
